FILE: rtl/core/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types for the signed integer divider: sequencer states and the
// control bundle that drives the datapath.
// ----------------------------------------------------------------------------
package sid_pkg;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_FIN  = 3'b100
  } sid_state_e;

  typedef struct packed {
    logic load;    // capture operands
    logic step;    // one restoring shift-subtract step
    logic finish;  // apply sign or saturation, register the quotient
  } sid_ctrl_t;

endpackage

FILE: rtl/core/sid_unit.sv
// ----------------------------------------------------------------------------
// sid_unit
// Divider datapath: operand magnitudes, one shared subtractor that produces
// one quotient bit per step, and the final sign and saturation stage.
// ----------------------------------------------------------------------------
module sid_unit import sid_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  sid_ctrl_t                    ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output logic signed [DATA_WIDTH-1:0] quotient_o
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] AllOnes = {W{1'b1}};

  logic [W-1:0] dvd_q, dvd_d;   // dividend bits out at top, quotient bits in at bottom
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] mb_q, mb_d;
  logic         neg_q, neg_d;
  logic         sat_q, sat_d;
  logic [W-1:0] quo_q, quo_d;

  logic [W-1:0] a_u, b_u;
  logic [W-1:0] trial;
  logic [W:0]   diff;
  logic         take;

  assign a_u   = dividend_i;
  assign b_u   = divisor_i;
  assign trial = {rem_q[W-2:0], dvd_q[W-1]};
  assign diff  = {1'b0, trial} - {1'b0, mb_q};
  assign take  = ~diff[W];

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    mb_d  = mb_q;
    neg_d = neg_q;
    sat_d = sat_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      dvd_d = a_u[W-1] ? (~a_u + 1'b1) : a_u;
      mb_d  = b_u[W-1] ? (~b_u + 1'b1) : b_u;
      rem_d = '0;
      neg_d = a_u[W-1] ^ b_u[W-1];
      sat_d = (b_u == '0) || ((a_u == MinVal) && (b_u == AllOnes));
    end else if (ctrl_i.step) begin
      rem_d = take ? diff[W-1:0] : trial;
      dvd_d = {dvd_q[W-2:0], take};
    end
    if (ctrl_i.finish) begin
      if (sat_q) begin
        quo_d = MaxVal;
      end else if (neg_q) begin
        quo_d = ~dvd_q + 1'b1;
      end else begin
        quo_d = dvd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    sat_q <= sat_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/sid_ctrl.sv
// ----------------------------------------------------------------------------
// sid_ctrl
// Divider sequencer: accepts a transaction, counts one step per quotient bit,
// then finishes and raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module sid_ctrl import sid_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  output sid_ctrl_t ctrl_o
);

  localparam int CntW = $clog2(DATA_WIDTH);
  localparam logic [CntW-1:0] LastStep = CntW'(DATA_WIDTH - 1);

  sid_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;

  assign busy          = (state_q != S_IDLE);
  assign ctrl_o.load   = start && (state_q == S_IDLE);
  assign ctrl_o.step   = (state_q == S_CALC);
  assign ctrl_o.finish = (state_q == S_FIN);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CALC;
          cnt_d   = LastStep;
        end
      end
      S_CALC: begin
        // advance until the last quotient bit is produced
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= ctrl_o.finish;
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/core/signed_int_divider.sv
// ----------------------------------------------------------------------------
// signed_int_divider
// The result strobe is registered after the load, the calc steps (one per
// quotient bit) and the finish state; no new transaction is accepted while
// busy, and the shared subtractor produces one quotient bit per cycle.
// A new transaction may be accepted in the cycle the strobe is high.
// Reset clears the sequencer and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_int_divider import sid_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output logic signed [DATA_WIDTH-1:0] quotient_o,
  output logic                         done_o
);

  sid_ctrl_t ctrl;

  sid_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .ctrl_o(ctrl)
  );

  sid_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_unit (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .dividend_i(dividend_i),
    .divisor_i (divisor_i),
    .quotient_o(quotient_o)
  );

endmodule

FILE: rtl/core/sid_checker.sv
// ----------------------------------------------------------------------------
// sid_assertions
// Port-level checks for the signed integer divider: strobe latency, busy
// after accept, strobe only when idle, zero-divisor saturation, zero dividend.
// ----------------------------------------------------------------------------
module sid_assertions #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic signed [DATA_WIDTH-1:0] dividend_i,
  input logic signed [DATA_WIDTH-1:0] divisor_i,
  input logic signed [DATA_WIDTH-1:0] quotient_o,
  input logic                         done_o
);

  localparam logic [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic accept;
  assign accept = start && !busy;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(DATA_WIDTH + 2) done_o)
    else $error("result strobe missing after fixed latency");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("divider not busy after accepting a transaction");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while divider still busy");

  a_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (divisor_i == '0)) |-> ##(DATA_WIDTH + 2) (quotient_o == MaxVal))
    else $error("zero divisor did not saturate");

  a_dividend_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (dividend_i == '0) && (divisor_i != '0))
      |-> ##(DATA_WIDTH + 2) (quotient_o == '0))
    else $error("zero dividend gave a nonzero quotient");

endmodule

bind signed_int_divider sid_assertions #(.DATA_WIDTH(DATA_WIDTH)) u_sid_assertions (.*);
